// ===== hdl/thp_pkg.sv =====
// Package for the temperature, pressure and humidity compensation core.
// Holds beat payload types, register codes, pipeline records and arithmetic helpers.
// No dependencies; every other file in hdl imports it.
package thp_pkg;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int DIV_STEPS  = 64;

   localparam logic [2:0] REG_TEMP_CAL  = 3'd0;
   localparam logic [2:0] REG_PRES_LOW  = 3'd1;
   localparam logic [2:0] REG_PRES_HIGH = 3'd2;
   localparam logic [2:0] REG_PRES_LAST = 3'd3;
   localparam logic [2:0] REG_HUM_CAL   = 3'd4;

   localparam logic [31:0] HUM_MAX = 32'd419430400;

   typedef struct packed {
      logic [19:0] adc_temperature;
      logic [19:0] adc_pressure;
      logic [15:0] adc_humidity;
   } thp_req_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_q24_8;
      logic [16:0]        humidity_q22_10;
   } thp_rsp_type;

   typedef struct packed {
      logic [63:0] p0;
      logic [31:0] p1;
      logic [31:0] p2;
   } pp_type;

   typedef struct packed {
      logic [63:0] r;
      logic [63:0] nq;
      logic [63:0] d;
      logic        neg;
      logic        zero;
   } div_stage_type;

   typedef struct packed {
      logic [31:0] temp;
      logic [16:0] hum;
   } side_type;

   function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned sh);
      return $signed(v) >>> sh;
   endfunction

   function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned sh);
      return $signed(v) >>> sh;
   endfunction

   function automatic pp_type mul_pp(input logic [63:0] a, input logic [63:0] b);
      pp_type pp;
      pp.p0 = 64'(a[31:0]) * 64'(b[31:0]);
      pp.p1 = a[63:32] * b[31:0];
      pp.p2 = a[31:0] * b[63:32];
      return pp;
   endfunction

   function automatic logic [63:0] mul_fin(input pp_type pp);
      logic [31:0] hi;
      hi = pp.p1 + pp.p2;
      return pp.p0 + {hi, 32'h0};
   endfunction

   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type res;
      logic [64:0]   t;
      logic [64:0]   diff;
      res  = s;
      t    = {s.r, s.nq[63]};
      diff = t - {1'b0, s.d};
      res.r  = diff[64] ? t[63:0] : diff[63:0];
      res.nq = {s.nq[62:0], ~diff[64]};
      return res;
   endfunction

endpackage

// ===== hdl/thp_div_pipe.sv =====
// Pipelined signed 64-bit divider with a carried sideband record.
// One restoring quotient bit per stage; depends on thp_pkg.
module thp_div_pipe import thp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_vld,
   input  logic [63:0] num,
   input  logic [63:0] den,
   input  side_type    in_side,
   output logic        out_vld,
   output logic [63:0] quo,
   output logic        out_zero,
   output side_type    out_side
);

   logic [DIV_STEPS:0] vld_ff;
   div_stage_type      stg_ff [DIV_STEPS+1];
   side_type           side_ff [DIV_STEPS+1];
   logic               out_vld_ff;
   logic [63:0]        quo_ff;
   logic               zero_ff;
   side_type           oside_ff;
   div_stage_type      prep_in;

   always_comb begin
      prep_in.r    = 64'h0;
      prep_in.nq   = num[63] ? (64'h0 - num) : num;
      prep_in.d    = den[63] ? (64'h0 - den) : den;
      prep_in.neg  = num[63] ^ den[63];
      prep_in.zero = (den == 64'h0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff     <= {vld_ff[DIV_STEPS-1:0], in_vld};
         out_vld_ff <= vld_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stg_ff[0]  <= prep_in;
         side_ff[0] <= in_side;
         for (int i = 1; i <= DIV_STEPS; i++) begin
            stg_ff[i]  <= div_step(stg_ff[i-1]);
            side_ff[i] <= side_ff[i-1];
         end
         quo_ff   <= stg_ff[DIV_STEPS].neg ? (64'h0 - stg_ff[DIV_STEPS].nq)
                                           : stg_ff[DIV_STEPS].nq;
         zero_ff  <= stg_ff[DIV_STEPS].zero;
         oside_ff <= side_ff[DIV_STEPS];
      end
   end

   assign out_vld  = out_vld_ff;
   assign quo      = quo_ff;
   assign out_zero = zero_ff;
   assign out_side = oside_ff;

endmodule

// ===== hdl/thp_sensor_compensation_core.sv =====
// Temperature, pressure and humidity compensation core, top level.
// Latency from an accepted req beat to rsp_valid is dominated by the 64-stage divider.
// Throughput: one beat per cycle; a stalled rsp beat freezes the whole pipeline.
// Reset clears the calibration registers and every valid bit; payload is not reset.
// Depends on thp_pkg and thp_div_pipe.
module thp_sensor_compensation_core import thp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  thp_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output thp_rsp_type           rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [47:0] tcal_ff;
   logic [63:0] plo_ff;
   logic [63:0] phi_ff;
   logic [15:0] plast_ff;
   logic [63:0] hcal_ff;
   logic [2:0]  reg_idx;

   assign reg_idx = paddr[CSR_ADDR_W-1:3];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tcal_ff  <= '0;
         plo_ff   <= '0;
         phi_ff   <= '0;
         plast_ff <= '0;
         hcal_ff  <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            REG_TEMP_CAL:  tcal_ff  <= pwdata[47:0];
            REG_PRES_LOW:  plo_ff   <= pwdata;
            REG_PRES_HIGH: phi_ff   <= pwdata;
            REG_PRES_LAST: plast_ff <= pwdata[15:0];
            REG_HUM_CAL:   hcal_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_TEMP_CAL:  prdata = {16'h0, tcal_ff};
         REG_PRES_LOW:  prdata = plo_ff;
         REG_PRES_HIGH: prdata = phi_ff;
         REG_PRES_LAST: prdata = {48'h0, plast_ff};
         REG_HUM_CAL:   prdata = hcal_ff;
         default:       prdata = '0;
      endcase
   end

   logic [15:0] t1;
   logic [31:0] t2s, t3s;
   logic [63:0] p1z, p2s, p3s, p4s, p5s, p6s, p7s, p8s, p9s;
   logic [31:0] h1, h2s, h3, h4s, h5s, h6s;

   assign t1  = tcal_ff[15:0];
   assign t2s = {{16{tcal_ff[31]}}, tcal_ff[31:16]};
   assign t3s = {{16{tcal_ff[47]}}, tcal_ff[47:32]};
   assign p1z = {48'h0, plo_ff[15:0]};
   assign p2s = {{48{plo_ff[31]}}, plo_ff[31:16]};
   assign p3s = {{48{plo_ff[47]}}, plo_ff[47:32]};
   assign p4s = {{48{plo_ff[63]}}, plo_ff[63:48]};
   assign p5s = {{48{phi_ff[15]}}, phi_ff[15:0]};
   assign p6s = {{48{phi_ff[31]}}, phi_ff[31:16]};
   assign p7s = {{48{phi_ff[47]}}, phi_ff[47:32]};
   assign p8s = {{48{phi_ff[63]}}, phi_ff[63:48]};
   assign p9s = {{48{plast_ff[15]}}, plast_ff};
   assign h1  = {24'h0, hcal_ff[7:0]};
   assign h2s = {{16{hcal_ff[23]}}, hcal_ff[23:8]};
   assign h3  = {24'h0, hcal_ff[31:24]};
   assign h4s = {{20{hcal_ff[43]}}, hcal_ff[43:32]};
   assign h5s = {{20{hcal_ff[55]}}, hcal_ff[55:44]};
   assign h6s = {{24{hcal_ff[63]}}, hcal_ff[63:56]};

   logic        advance;
   logic        rsp_valid_ff;
   thp_rsp_type rsp_data_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   logic [11:0] pre_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= '0;
      end else if (advance) begin
         pre_vld_ff <= {pre_vld_ff[10:0], req_valid};
      end
   end

   logic [19:0] at1_ff;
   logic [19:0] ap_ff [1:9];
   logic [15:0] ah_ff [1:5];
   logic [31:0] m1_ff, dd_ff, v1t_ff, m2_ff, tf_ff;
   logic [31:0] x_in, d_in, pv_hi;
   logic [63:0] pv_in;
   logic [31:0] hv_in;
   pp_type      ppvv_ff, ppv5_ff, ppv2_ff, pp6_ff, pp3_ff, pps_ff, ppn_ff;
   logic [31:0] hm5_ff, hb6_ff, hc3_ff;
   logic [31:0] tc_ff [5:12];
   logic [63:0] sq6_ff, a6_ff, a3_ff, v2a_ff, s9_ff, num10_ff, s11_ff;
   logic [63:0] vp5_ff [6:8];
   logic [63:0] vp2_ff [6:8];
   logic [31:0] ha_ff [6:8];
   logic [31:0] hb_ff, hc_ff, he7_ff, hf8_ff, hg9_ff, hgg10_ff, hgh11_ff;
   logic [31:0] hvv_ff [9:11];
   logic [63:0] dvs12_ff, num12_ff;
   logic [16:0] hum12_ff;
   logic [31:0] hraw, hcl;

   assign x_in  = {15'h0, at1_ff[19:3]} - {15'h0, t1, 1'b0};
   assign d_in  = {16'h0, at1_ff[19:4]} - {16'h0, t1};
   assign pv_hi = {32{tf_ff[31]}};
   assign pv_in = {pv_hi, tf_ff} - 64'd128000;
   assign hv_in = tf_ff - 32'd768000;

   always_comb begin
      hraw = hvv_ff[11] - asr32(hgh11_ff, 4);
      if (hraw[31]) begin
         hcl = 32'h0;
      end else if (hraw > HUM_MAX) begin
         hcl = HUM_MAX;
      end else begin
         hcl = hraw;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         at1_ff   <= req_data.adc_temperature;
         ap_ff[1] <= req_data.adc_pressure;
         ah_ff[1] <= req_data.adc_humidity;
         for (int i = 2; i <= 9; i++) ap_ff[i] <= ap_ff[i-1];
         for (int i = 2; i <= 5; i++) ah_ff[i] <= ah_ff[i-1];

         m1_ff  <= x_in * t2s;
         dd_ff  <= d_in * d_in;
         v1t_ff <= asr32(m1_ff, 11);
         m2_ff  <= asr32(dd_ff, 12) * t3s;
         tf_ff  <= v1t_ff + asr32(m2_ff, 14);

         ppvv_ff  <= mul_pp(pv_in, pv_in);
         ppv5_ff  <= mul_pp(pv_in, p5s);
         ppv2_ff  <= mul_pp(pv_in, p2s);
         hm5_ff   <= h5s * hv_in;
         hb6_ff   <= hv_in * h6s;
         hc3_ff   <= hv_in * h3;
         tc_ff[5] <= asr32(tf_ff * 32'd5 + 32'd128, 8);
         for (int i = 6; i <= 12; i++) tc_ff[i] <= tc_ff[i-1];

         sq6_ff    <= mul_fin(ppvv_ff);
         vp5_ff[6] <= mul_fin(ppv5_ff);
         vp2_ff[6] <= mul_fin(ppv2_ff);
         for (int i = 7; i <= 8; i++) begin
            vp5_ff[i] <= vp5_ff[i-1];
            vp2_ff[i] <= vp2_ff[i-1];
            ha_ff[i]  <= ha_ff[i-1];
         end
         ha_ff[6] <= asr32(({16'h0, ah_ff[5]} << 14) - (h4s << 20) - hm5_ff + 32'd16384, 15);
         hb_ff    <= asr32(hb6_ff, 10);
         hc_ff    <= asr32(hc3_ff, 11) + 32'd32768;

         pp6_ff <= mul_pp(sq6_ff, p6s);
         pp3_ff <= mul_pp(sq6_ff, p3s);
         he7_ff <= asr32(hb_ff * hc_ff, 10) + 32'd2097152;

         a6_ff  <= mul_fin(pp6_ff);
         a3_ff  <= mul_fin(pp3_ff);
         hf8_ff <= asr32(he7_ff * h2s + 32'd8192, 14);

         v2a_ff    <= a6_ff + (vp5_ff[8] << 17) + (p4s << 35);
         s9_ff     <= 64'h0000_8000_0000_0000 + asr64(a3_ff, 8) + (vp2_ff[8] << 12);
         hvv_ff[9] <= ha_ff[8] * hf8_ff;
         hg9_ff    <= asr32(ha_ff[8] * hf8_ff, 15);

         pps_ff     <= mul_pp(s9_ff, p1z);
         num10_ff   <= ((64'd1048576 - {44'h0, ap_ff[9]}) << 31) - v2a_ff;
         hgg10_ff   <= hg9_ff * hg9_ff;
         hvv_ff[10] <= hvv_ff[9];

         s11_ff     <= mul_fin(pps_ff);
         ppn_ff     <= mul_pp(num10_ff, 64'd3125);
         hgh11_ff   <= asr32(hgg10_ff, 7) * h1;
         hvv_ff[11] <= hvv_ff[10];

         dvs12_ff <= asr64(s11_ff, 33);
         num12_ff <= mul_fin(ppn_ff);
         hum12_ff <= hcl[28:12];
      end
   end

   side_type    div_side_in, div_side_out;
   logic        div_vld, div_zero;
   logic [63:0] div_quo;

   assign div_side_in.temp = tc_ff[12];
   assign div_side_in.hum  = hum12_ff;

   thp_div_pipe u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_vld   (pre_vld_ff[11]),
      .num      (num12_ff),
      .den      (dvs12_ff),
      .in_side  (div_side_in),
      .out_vld  (div_vld),
      .quo      (div_quo),
      .out_zero (div_zero),
      .out_side (div_side_out)
   );

   logic [4:0]  post_vld_ff;
   logic [63:0] pq_ff [1:4];
   logic [63:0] ph_ff [1:2];
   logic [63:0] a8_ff [2:4];
   logic        zr_ff [1:5];
   side_type    sd_ff [1:5];
   pp_type      pp9_ff, pp8_ff, pph_ff;
   logic [63:0] a9h_ff, b_ff, s_ff, pfin;

   assign pfin = asr64(s_ff, 8) + (p7s << 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         post_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         post_vld_ff  <= {post_vld_ff[3:0], div_vld};
         rsp_valid_ff <= post_vld_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pq_ff[1] <= div_quo;
         ph_ff[1] <= asr64(div_quo, 13);
         zr_ff[1] <= div_zero;
         sd_ff[1] <= div_side_out;
         pp9_ff   <= mul_pp(p9s, asr64(div_quo, 13));
         pp8_ff   <= mul_pp(p8s, div_quo);
         for (int i = 2; i <= 5; i++) begin
            zr_ff[i] <= zr_ff[i-1];
            sd_ff[i] <= sd_ff[i-1];
         end
         for (int i = 2; i <= 4; i++) pq_ff[i] <= pq_ff[i-1];
         ph_ff[2] <= ph_ff[1];

         a9h_ff   <= mul_fin(pp9_ff);
         a8_ff[2] <= mul_fin(pp8_ff);
         a8_ff[3] <= a8_ff[2];
         a8_ff[4] <= a8_ff[3];
         pph_ff   <= mul_pp(a9h_ff, ph_ff[2]);
         b_ff     <= mul_fin(pph_ff);
         s_ff     <= pq_ff[4] + asr64(b_ff, 25) + asr64(a8_ff[4], 19);

         rsp_data_ff.temperature_centi <= $signed(sd_ff[5].temp);
         rsp_data_ff.humidity_q22_10   <= sd_ff[5].hum;
         rsp_data_ff.pressure_q24_8    <= zr_ff[5] ? 32'h0 : pfin[31:0];
      end
   end

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      $past(req_stall) |-> $stable(pre_vld_ff))
      else $error("pipeline valid bits moved during a stall");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled without a pending rsp beat");

   a_hum_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.humidity_q22_10 <= 17'd102400))
      else $error("humidity above full scale");

endmodule

// ===== verif/thp_compensation_checker.sv =====
`timescale 1ns / 100ps
// Checker for the sensor compensation core: snoops calibration writes and req beats,
// predicts each compensated reading and compares it with the rsp beats. Uses thp_pkg.
module thp_compensation_checker import thp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  thp_req_type           req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  thp_rsp_type           rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    failures,
   output int                    pending
);

   logic [47:0] temp_cal;
   logic [63:0] pres_cal_low;
   logic [63:0] pres_cal_high;
   logic [15:0] pres_cal_last;
   logic [63:0] hum_cal;
   thp_rsp_type readings_due[$];

   function automatic logic [31:0] shr32(input logic [31:0] v, input int sh);
      logic signed [31:0] s;
      s = v;
      return s >>> sh;
   endfunction

   function automatic logic [63:0] shr64(input logic [63:0] v, input int sh);
      logic signed [63:0] s;
      s = v;
      return s >>> sh;
   endfunction

   function automatic logic [63:0] ext16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] quotient(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] un, ud, q;
      un = n[63] ? -n : n;
      ud = d[63] ? -d : d;
      q = un / ud;
      return (n[63] != d[63]) ? -q : q;
   endfunction

   function automatic thp_rsp_type compensate(input thp_req_type s);
      thp_rsp_type r;
      logic [31:0] t1, t2, t3, x, d, tf, adc;
      logic [63:0] q1, q2, q3, q4, q5, q6, q7, q8, q9, v1, v2, p;
      logic [31:0] h1, h2, h3, h4, h5, h6, v, a, b, c, e, f, g;
      adc = {12'd0, s.adc_temperature};
      t1 = {16'd0, temp_cal[15:0]};
      t2 = 32'(ext16(temp_cal[31:16]));
      t3 = 32'(ext16(temp_cal[47:32]));
      x = (adc >> 3) - (t1 << 1);
      d = (adc >> 4) - t1;
      tf = shr32(x * t2, 11) + shr32(shr32(d * d, 12) * t3, 14);
      r.temperature_centi = shr32(tf * 32'd5 + 32'd128, 8);

      q1 = {48'd0, pres_cal_low[15:0]};
      q2 = ext16(pres_cal_low[31:16]);
      q3 = ext16(pres_cal_low[47:32]);
      q4 = ext16(pres_cal_low[63:48]);
      q5 = ext16(pres_cal_high[15:0]);
      q6 = ext16(pres_cal_high[31:16]);
      q7 = ext16(pres_cal_high[47:32]);
      q8 = ext16(pres_cal_high[63:48]);
      q9 = ext16(pres_cal_last);
      v1 = {{32{tf[31]}}, tf} - 64'd128000;
      v2 = v1 * v1 * q6;
      v2 = v2 + ((v1 * q5) << 17);
      v2 = v2 + (q4 << 35);
      v1 = shr64(v1 * v1 * q3, 8) + ((v1 * q2) << 12);
      v1 = shr64(((64'd1 << 47) + v1) * q1, 33);
      if (v1 == 64'd0) begin
         r.pressure_q24_8 = 32'd0;
      end else begin
         p = 64'd1048576 - {44'd0, s.adc_pressure};
         p = quotient(((p << 31) - v2) * 64'd3125, v1);
         v1 = shr64(q9 * shr64(p, 13) * shr64(p, 13), 25);
         v2 = shr64(q8 * p, 19);
         p = shr64(p + v1 + v2, 8) + (q7 << 4);
         r.pressure_q24_8 = p[31:0];
      end

      h1 = {24'd0, hum_cal[7:0]};
      h2 = {{16{hum_cal[23]}}, hum_cal[23:8]};
      h3 = {24'd0, hum_cal[31:24]};
      h4 = {{20{hum_cal[43]}}, hum_cal[43:32]};
      h5 = {{20{hum_cal[55]}}, hum_cal[55:44]};
      h6 = {{24{hum_cal[63]}}, hum_cal[63:56]};
      v = tf - 32'd768000;
      a = ({16'd0, s.adc_humidity} << 14) - (h4 << 20) - h5 * v;
      a = shr32(a + 32'd16384, 15);
      b = shr32(v * h6, 10);
      c = shr32(v * h3, 11) + 32'd32768;
      e = shr32(b * c, 10) + 32'd2097152;
      f = shr32(e * h2 + 32'd8192, 14);
      v = a * f;
      g = shr32(v, 15);
      v = v - shr32(shr32(g * g, 7) * h1, 4);
      if (v[31]) v = 32'd0;
      else if (v > HUM_MAX) v = HUM_MAX;
      r.humidity_q22_10 = 17'(v >> 12);
      return r;
   endfunction

   always @(posedge clock) begin
      thp_rsp_type want;
      if (reset) begin
         temp_cal <= '0;
         pres_cal_low <= '0;
         pres_cal_high <= '0;
         pres_cal_last <= '0;
         hum_cal <= '0;
         failures <= 0;
         pending <= 0;
         readings_due.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:3])
               REG_TEMP_CAL:  temp_cal <= pwdata[47:0];
               REG_PRES_LOW:  pres_cal_low <= pwdata;
               REG_PRES_HIGH: pres_cal_high <= pwdata;
               REG_PRES_LAST: pres_cal_last <= pwdata[15:0];
               REG_HUM_CAL:   hum_cal <= pwdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) readings_due.push_back(compensate(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (readings_due.size() == 0) begin
               $display("%0t: unexpected rsp beat %h", $time, rsp_data);
               failures <= failures + 1;
            end else begin
               want = readings_due.pop_front();
               if (want != rsp_data) begin
                  $display("%0t: mismatch temperature exp %0d act %0d", $time,
                           want.temperature_centi, rsp_data.temperature_centi);
                  $display("%0t: mismatch pressure exp %0d act %0d", $time,
                           want.pressure_q24_8, rsp_data.pressure_q24_8);
                  $display("%0t: mismatch humidity exp %0d act %0d", $time,
                           want.humidity_q22_10, rsp_data.humidity_q22_10);
                  failures <= failures + 1;
               end
            end
         end
         pending <= readings_due.size();
      end
   end

endmodule

// ===== verif/tb_thp_sensor_compensation_core.sv =====
`timescale 1ns / 100ps
// Testbench top for the sensor compensation core: clock, reset, calibration writes,
// bursty req beats and a stalling receiver. Uses thp_pkg and thp_compensation_checker.
module tb_thp_sensor_compensation_core;
   import thp_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   thp_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   thp_rsp_type           rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    failures;
   int                    pending;
   int                    cycles;
   int                    hold_req;
   int                    burst_left;

   thp_sensor_compensation_core dut (.*);

   thp_compensation_checker checker_i (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_data(rsp_data), .psel(psel), .penable(penable), .pwrite(pwrite),
      .pready(pready), .paddr(paddr), .pwdata(pwdata), .failures(failures),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: random stall segments, plus a long hold-off on request.
   initial begin
      int seg, mode, served;
      served = 0;
      rsp_stall = 1'b0;
      forever begin
         if (hold_req != served) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
            served = hold_req;
         end
         seg = $urandom_range(200, 20);
         mode = $urandom_range(2, 0);
         repeat (seg) begin
            rsp_stall <= (mode == 0) ? 1'b0 :
                         (mode == 1) ? ($urandom_range(9, 0) < 3) :
                                       ($urandom_range(3, 0) != 0);
            @(posedge clock);
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'({idx, 3'b000});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_calibration(input logic [47:0] t, input logic [63:0] pl,
                                   input logic [63:0] ph, input logic [15:0] p9,
                                   input logic [63:0] h);
      csr_write(REG_TEMP_CAL, {16'hFFFF, t});
      csr_write(REG_PRES_LOW, pl);
      csr_write(REG_PRES_HIGH, ph);
      csr_write(REG_PRES_LAST, {48'hFFFF_FFFF_FFFF, p9});
      csr_write(REG_HUM_CAL, h);
   endtask

   task automatic load_typical();
      load_calibration({16'hFC18, 16'd26435, 16'd27504},
                       {16'd2855, 16'd3024, 16'hD843, 16'd36477},
                       {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000,
                       {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75});
   endtask

   // The last beat has already been accepted when this is called.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Offers one beat; gaps between bursts lower valid only after acceptance.
   task automatic send_beat(input thp_req_type s);
      req_valid <= 1'b1;
      req_data <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
         burst_left = $urandom_range(30, 1);
      end else begin
         burst_left--;
      end
   endtask

   function automatic thp_req_type random_sample();
      thp_req_type s;
      if ($urandom_range(3, 0) == 0) begin
         s.adc_temperature = 20'($urandom);
         s.adc_pressure = 20'($urandom);
         s.adc_humidity = 16'($urandom);
      end else begin
         s.adc_temperature = 20'($urandom_range(560000, 480000));
         s.adc_pressure = 20'($urandom_range(450000, 250000));
         s.adc_humidity = 16'($urandom_range(40000, 20000));
      end
      return s;
   endfunction

   task automatic random_run(input int count);
      repeat (count) send_beat(random_sample());
   endtask

   initial begin
      thp_req_type s;
      logic [19:0] edges20[4];
      logic [15:0] edges16[3];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cycles = 0;
      burst_left = 0;
      edges20 = '{20'd0, 20'd1, 20'hFFFFF, 20'd519888};
      edges16 = '{16'd0, 16'hFFFF, 16'd30000};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset calibration: zero pressure divisor.
      send_beat('{20'd519888, 20'd415148, 16'd30000});
      wait_drained();

      load_typical();
      csr_write(3'd5, '1);
      csr_write(3'd7, '1);
      foreach (edges20[i]) begin
         s.adc_temperature = edges20[i];
         s.adc_pressure = edges20[3 - i];
         s.adc_humidity = edges16[i % 3];
         send_beat(s);
      end
      send_beat('{20'd519888, 20'd415148, 16'hFFFF});
      send_beat('{20'd519888, 20'd415148, 16'd0});
      send_beat('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
      send_beat('{20'd0, 20'd0, 16'd0});
      wait_drained();

      load_calibration('0, '0, '0, '0, '0);
      random_run(10);
      wait_drained();
      load_calibration('1, '1, '1, '1, '1);
      random_run(20);
      wait_drained();
      load_calibration({16'h7FFF, 16'h7FFF, 16'hFFFF},
                       {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF}, {4{16'h7FFF}},
                       16'h7FFF, {8'h7F, 12'h7FF, 12'h7FF, 8'hFF, 16'h7FFF, 8'hFF});
      random_run(20);
      wait_drained();
      load_calibration({16'h8000, 16'h8000, 16'h0001},
                       {16'h8000, 16'h8000, 16'h8000, 16'h0001}, {4{16'h8000}},
                       16'h8000, {8'h80, 12'h800, 12'h800, 8'h00, 16'h8000, 8'h00});
      random_run(20);
      wait_drained();

      // Fill the pipeline against a held-off receiver.
      load_typical();
      hold_req++;
      random_run(300);
      wait_drained();

      repeat (6) begin
         load_calibration({$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, 16'($urandom), {$urandom, $urandom});
         random_run(120);
         wait_drained();
      end
      load_typical();
      random_run(900);
      wait_drained();
      repeat (100) @(posedge clock);

      if (failures == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/thp_pkg.sv
hdl/thp_div_pipe.sv
hdl/thp_sensor_compensation_core.sv
verif/thp_compensation_checker.sv
verif/tb_thp_sensor_compensation_core.sv
